### rtl/mssh_pkg.sv
// ----------------------------------------------------------------------------
// mssh_pkg: shared types and constants of the motor speed control block
// Item layouts, configuration bundle, command codes and the constants of
// the sample-to-angle conversion.
// ----------------------------------------------------------------------------
package mssh_pkg;

  localparam int SAMPLE_WIDTH = 12;
  localparam int DUTY_WIDTH   = 14;

  // Register field widths
  localparam int CFG_DUTY_W  = 14;
  localparam int CFG_STEP_W  = 12;
  localparam int CFG_LIMIT_W = 4;
  localparam int CFG_FS_W    = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 3;

  localparam int ANGLE_W = CFG_FS_W;
  localparam int LAST_W  = ANGLE_W + 1;

  // Angle conversion: angle = floor((s * fs + (M - 1) / 2) / M), M = 2^SW - 1
  localparam int PROD_W  = SAMPLE_WIDTH + CFG_FS_W;
  localparam int RECIP_W = 17;
  localparam int MUL_W   = PROD_W + RECIP_W;
  localparam logic [63:0] SAMPLE_MAX_WIDE = (64'd1 << SAMPLE_WIDTH) - 64'd1;
  localparam logic [63:0] RECIP_WIDE      = (64'd1 << PROD_W) / SAMPLE_MAX_WIDE;
  localparam logic [PROD_W-1:0]  SAMPLE_MAX = SAMPLE_MAX_WIDE[PROD_W-1:0];
  localparam logic [PROD_W-1:0]  HALF_MAX   = SAMPLE_MAX >> 1;
  localparam logic [RECIP_W-1:0] RECIP      = RECIP_WIDE[RECIP_W-1:0];

  // Detector input on every stop, tenths of a degree
  localparam logic [LAST_W-1:0] STOP_SENTINEL = LAST_W'(-1000);

  // Item kinds
  localparam logic [2:0] KIND_SET_SPEED = 3'd0;
  localparam logic [2:0] KIND_REVERSE   = 3'd1;
  localparam logic [2:0] KIND_HOME      = 3'd2;
  localparam logic [2:0] KIND_STALL     = 3'd3;
  localparam logic [2:0] KIND_ANGLE     = 3'd4;

  // Speed levels
  localparam logic [1:0] LVL_STOP   = 2'd0;
  localparam logic [1:0] LVL_LOW    = 2'd1;
  localparam logic [1:0] LVL_MEDIUM = 2'd2;
  localparam logic [1:0] LVL_HIGH   = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MEDIUM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REACH_TOL   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE  = 3'd6;

  typedef struct packed {
    logic [2:0]              kind;
    logic [2:0]              speed_request;
    logic [SAMPLE_WIDTH-1:0] adc_sample;
    logic                    adc_ok;
  } in_word_t;

  typedef struct packed {
    logic [DUTY_WIDTH-1:0] duty_forward;
    logic [DUTY_WIDTH-1:0] duty_backward;
    logic [1:0]            level_now;
    logic                  dir_now;
    logic [ANGLE_W-1:0]    angle_tenths;
    logic                  stall_trip;
    logic                  target_reached;
    logic                  homing_busy;
  } out_word_t;

  typedef struct packed {
    logic [CFG_DUTY_W-1:0]  duty_low;
    logic [CFG_DUTY_W-1:0]  duty_medium;
    logic [CFG_DUTY_W-1:0]  duty_high;
    logic [CFG_STEP_W-1:0]  stall_step_tenths;
    logic [CFG_LIMIT_W-1:0] stall_repeat_limit;
    logic [CFG_STEP_W-1:0]  reach_tolerance_tenths;
    logic [CFG_FS_W-1:0]    full_scale_tenths;
  } cfg_t;

  // Fit a register duty value to the output duty width
  function automatic logic [DUTY_WIDTH-1:0] to_duty(input logic [CFG_DUTY_W-1:0] val);
    logic [31:0] wide;
    begin
      wide = {{(32 - CFG_DUTY_W){1'b0}}, val};
      return wide[DUTY_WIDTH-1:0];
    end
  endfunction

endpackage

### rtl/mssh_angle_conv.sv
// ----------------------------------------------------------------------------
// mssh_angle_conv: sample to angle conversion pipeline
// Three stages: scale by full scale with rounding bias, reciprocal multiply,
// remainder correction. Words pass through with their angle attached.
// ----------------------------------------------------------------------------
module mssh_angle_conv
  import mssh_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  in_word_t            up_word,
  input  logic [CFG_FS_W-1:0] full_scale,
  output logic                dn_valid,
  input  logic                dn_ready,
  output in_word_t            dn_word,
  output logic [ANGLE_W-1:0]  dn_angle
);

  logic               v1_r, v2_r, v3_r;
  in_word_t           w1_r, w2_r, w3_r;
  logic [PROD_W-1:0]  num1_r, num2_r;
  logic [ANGLE_W-1:0] quo2_r, angle3_r;

  logic               rdy1, rdy2, rdy3;
  logic [PROD_W-1:0]  num_nxt;
  logic [MUL_W-1:0]   recip_prod;
  logic [PROD_W-1:0]  quo_times_max;
  logic [PROD_W-1:0]  rem;
  logic [ANGLE_W-1:0] angle_nxt;

  assign rdy3     = !v3_r || dn_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;

  assign num_nxt    = PROD_W'(up_word.adc_sample) * PROD_W'(full_scale) + HALF_MAX;
  assign recip_prod = MUL_W'(num1_r) * MUL_W'(RECIP);

  // Estimate is low by at most one; the remainder tells
  assign quo_times_max = (PROD_W'(quo2_r) << SAMPLE_WIDTH) - PROD_W'(quo2_r);
  assign rem           = num2_r - quo_times_max;
  assign angle_nxt     = (rem >= SAMPLE_MAX) ? quo2_r + ANGLE_W'(1) : quo2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= up_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      w1_r   <= up_word;
      num1_r <= num_nxt;
    end
    if (rdy2 && v1_r) begin
      w2_r   <= w1_r;
      num2_r <= num1_r;
      quo2_r <= recip_prod[PROD_W +: ANGLE_W];
    end
    if (rdy3 && v2_r) begin
      w3_r     <= w2_r;
      angle3_r <= angle_nxt;
    end
  end

  assign dn_valid = v3_r;
  assign dn_word  = w3_r;
  assign dn_angle = angle3_r;

  a_rem_below_twice_max: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> rem < (SAMPLE_MAX << 1))
    else $error("conversion estimate off by more than one");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !dn_ready |=> v3_r && $stable(angle3_r))
    else $error("converted angle changed while held");

  a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && rdy3 |=> v3_r)
    else $error("middle stage word lost");

endmodule

### rtl/mssh_ctrl.sv
// ----------------------------------------------------------------------------
// mssh_ctrl: speed, direction, stall detector and homing state
// Applies one word per cycle when not stalled to the control state and
// loads the result register with the duties and status after that word.
// ----------------------------------------------------------------------------
module mssh_ctrl
  import mssh_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               up_valid,
  output logic               up_ready,
  input  in_word_t           up_word,
  input  logic [ANGLE_W-1:0] up_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output out_word_t          out_word
);

  typedef struct packed {
    logic [LAST_W-1:0]      last;
    logic [CFG_LIMIT_W-1:0] cnt;
    logic                   trip;
  } det_t;

  function automatic det_t stall_check(input logic [LAST_W-1:0] angle,
                                       input det_t cur,
                                       input logic [CFG_STEP_W-1:0] step,
                                       input logic [CFG_LIMIT_W-1:0] limit);
    det_t              res;
    logic [LAST_W:0]   diff;
    logic [LAST_W:0]   mag;
    logic [CFG_LIMIT_W-1:0] cnt;
    begin
      diff     = {angle[LAST_W-1], angle} - {cur.last[LAST_W-1], cur.last};
      mag      = diff[LAST_W] ? (~diff + (LAST_W+1)'(1)) : diff;
      res.last = angle;
      res.trip = 1'b0;
      res.cnt  = '0;
      if (mag <= (LAST_W+1)'(step)) begin
        cnt = (cur.cnt != '1) ? cur.cnt + CFG_LIMIT_W'(1) : cur.cnt;
        if (cnt >= limit) begin
          res.trip = 1'b1;
        end else begin
          res.cnt = cnt;
        end
      end
      return res;
    end
  endfunction

  logic                   dir_r, pend_r, homing_r;
  logic [1:0]             level_r;
  logic [LAST_W-1:0]      last_angle_r;
  logic [CFG_LIMIT_W-1:0] small_cnt_r;
  logic                   out_valid_r;
  out_word_t              out_word_r;

  logic                   dir_nxt, pend_nxt, homing_nxt;
  logic [1:0]             level_nxt;
  det_t                   det_cur, det_tick, det_stop, det_tick_stop, det_nxt;
  logic                   trip_nxt, reached_nxt;
  logic                   load, sample_used, at_home;
  logic [CFG_DUTY_W-1:0]  duty_sel;
  logic [DUTY_WIDTH-1:0]  duty;
  out_word_t              out_nxt;

  assign up_ready = !out_valid_r || !out_stall;
  assign load     = up_valid && up_ready;

  assign sample_used = up_word.adc_ok &&
                       (up_word.kind == KIND_HOME || up_word.kind == KIND_STALL ||
                        up_word.kind == KIND_ANGLE);
  assign at_home     = up_angle <= ANGLE_W'(cfg.reach_tolerance_tenths);

  assign det_cur       = '{last: last_angle_r, cnt: small_cnt_r, trip: 1'b0};
  assign det_tick      = stall_check({1'b0, up_angle}, det_cur,
                                     cfg.stall_step_tenths, cfg.stall_repeat_limit);
  assign det_stop      = stall_check(STOP_SENTINEL, det_cur,
                                     cfg.stall_step_tenths, cfg.stall_repeat_limit);
  assign det_tick_stop = stall_check(STOP_SENTINEL, det_tick,
                                     cfg.stall_step_tenths, cfg.stall_repeat_limit);

  always_comb begin
    dir_nxt     = dir_r;
    level_nxt   = level_r;
    pend_nxt    = pend_r;
    homing_nxt  = homing_r;
    det_nxt     = det_cur;
    trip_nxt    = 1'b0;
    reached_nxt = 1'b0;
    unique case (up_word.kind)
      KIND_SET_SPEED: begin
        level_nxt = (up_word.speed_request > 3'd3) ? LVL_MEDIUM : up_word.speed_request[1:0];
        if (level_nxt == LVL_STOP) begin
          det_nxt = det_stop;
        end
      end
      KIND_REVERSE: begin
        if (level_r != LVL_STOP) begin
          dir_nxt = ~dir_r;
        end
      end
      KIND_HOME: begin
        pend_nxt = 1'b1;
        if (up_word.adc_ok && at_home) begin
          level_nxt   = LVL_STOP;
          det_nxt     = det_stop;
          pend_nxt    = 1'b0;
          reached_nxt = 1'b1;
        end else begin
          homing_nxt = 1'b1;
          level_nxt  = LVL_LOW;
        end
      end
      KIND_STALL: begin
        if (level_r != LVL_STOP && up_word.adc_ok) begin
          det_nxt = det_tick;
          if (det_tick.trip) begin
            level_nxt = LVL_STOP;
            det_nxt   = det_tick_stop;
            trip_nxt  = 1'b1;
          end
        end
      end
      KIND_ANGLE: begin
        if (homing_r && up_word.adc_ok && pend_r && at_home) begin
          level_nxt   = LVL_STOP;
          det_nxt     = det_stop;
          homing_nxt  = 1'b0;
          pend_nxt    = 1'b0;
          reached_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    unique case (level_nxt)
      LVL_LOW:    duty_sel = cfg.duty_low;
      LVL_MEDIUM: duty_sel = cfg.duty_medium;
      LVL_HIGH:   duty_sel = cfg.duty_high;
      default:    duty_sel = '0;
    endcase
  end

  assign duty = to_duty(duty_sel);

  always_comb begin
    out_nxt.duty_forward   = dir_nxt ? duty : '0;
    out_nxt.duty_backward  = dir_nxt ? '0 : duty;
    out_nxt.level_now      = level_nxt;
    out_nxt.dir_now        = dir_nxt;
    out_nxt.angle_tenths   = sample_used ? up_angle : '0;
    out_nxt.stall_trip     = trip_nxt;
    out_nxt.target_reached = reached_nxt;
    out_nxt.homing_busy    = homing_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r        <= 1'b0;
      level_r      <= LVL_STOP;
      pend_r       <= 1'b0;
      homing_r     <= 1'b0;
      last_angle_r <= '0;
      small_cnt_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (up_ready) begin
        out_valid_r <= up_valid;
      end
      if (load) begin
        dir_r        <= dir_nxt;
        level_r      <= level_nxt;
        pend_r       <= pend_nxt;
        homing_r     <= homing_nxt;
        last_angle_r <= det_nxt.last;
        small_cnt_r  <= det_nxt.cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_trip_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_word_r.stall_trip || out_word_r.target_reached) |->
      out_word_r.level_now == LVL_STOP)
    else $error("stop event reported while still running");

  a_one_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_word_r.duty_forward == '0 || out_word_r.duty_backward == '0)
    else $error("both channels driven");

  a_reverse_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    load && up_word.kind == KIND_REVERSE && level_r == LVL_STOP |=>
      dir_r == $past(dir_r))
    else $error("direction flipped while stopped");

  a_state_matches_out: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_word_r.level_now == level_r && out_word_r.dir_now == dir_r &&
      out_word_r.homing_busy == homing_r)
    else $error("result word disagrees with control state");

endmodule

### rtl/motor_speed_stall_homing_control.sv
// ----------------------------------------------------------------------------
// motor_speed_stall_homing_control: two-channel motor drive control
// Path: a word accepted at the input passes the input register, three
//   conversion stages and the result register, in that order.
// Throughput: one word per cycle when not stalled; the scale multiply and
//   reciprocal multiply of the angle conversion sit in stages of their own.
// Reset: synchronous, active low; registers return to their defaults and
//   the motor state to stopped, reverse direction, no homing.
// ----------------------------------------------------------------------------
// Commands and sensor ticks enter as one word each. The sample of a word is
// turned into tenths of a degree by a short pipeline, then the control stage
// applies the word to the speed level, direction, stall detector and homing
// state and loads the result register. Every stage holds its own valid bit,
// so bubbles collapse and a new word is taken while a result still waits.
module motor_speed_stall_homing_control
  import mssh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input word channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  // Result word channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  // Register write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t               cfg_r;

  logic               in_valid_r;
  in_word_t           in_word_r;

  logic               conv_ready;
  logic               conv_valid;
  in_word_t           conv_word;
  logic [ANGLE_W-1:0] conv_angle;
  logic               ctrl_ready;

  // Registers: write only, taken at any edge with the enable high.
  // Indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.duty_low               <= CFG_DUTY_W'(7000);
      cfg_r.duty_medium            <= CFG_DUTY_W'(7555);
      cfg_r.duty_high              <= CFG_DUTY_W'(8192);
      cfg_r.stall_step_tenths      <= CFG_STEP_W'(30);
      cfg_r.stall_repeat_limit     <= CFG_LIMIT_W'(3);
      cfg_r.reach_tolerance_tenths <= CFG_STEP_W'(10);
      cfg_r.full_scale_tenths      <= CFG_FS_W'(3600);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DUTY_LOW:    cfg_r.duty_low               <= cfg_wdata[CFG_DUTY_W-1:0];
        CFG_DUTY_MEDIUM: cfg_r.duty_medium            <= cfg_wdata[CFG_DUTY_W-1:0];
        CFG_DUTY_HIGH:   cfg_r.duty_high              <= cfg_wdata[CFG_DUTY_W-1:0];
        CFG_STALL_STEP:  cfg_r.stall_step_tenths      <= cfg_wdata[CFG_STEP_W-1:0];
        CFG_STALL_LIMIT: cfg_r.stall_repeat_limit     <= cfg_wdata[CFG_LIMIT_W-1:0];
        CFG_REACH_TOL:   cfg_r.reach_tolerance_tenths <= cfg_wdata[CFG_STEP_W-1:0];
        CFG_FULL_SCALE:  cfg_r.full_scale_tenths      <= cfg_wdata[CFG_FS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register: hold the word only while the first conversion stage
  // is full and blocked.
  assign in_stall = in_valid_r && !conv_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_word_r <= in_word;
    end
  end

  // Sample to tenths of a degree, rounded half up.
  mssh_angle_conv u_conv (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_valid_r),
    .up_ready   (conv_ready),
    .up_word    (in_word_r),
    .full_scale (cfg_r.full_scale_tenths),
    .dn_valid   (conv_valid),
    .dn_ready   (ctrl_ready),
    .dn_word    (conv_word),
    .dn_angle   (conv_angle)
  );

  // Control state and result register. State advances once per word, at
  // the edge that moves it into the result register.
  mssh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .up_valid  (conv_valid),
    .up_ready  (ctrl_ready),
    .up_word   (conv_word),
    .up_angle  (conv_angle),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> in_valid_r && $stable(in_word_r))
    else $error("input word dropped while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> conv_valid)
    else $error("input stalled with an empty pipeline tail");

  a_out_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !ctrl_ready |-> out_valid && out_stall)
    else $error("control stage blocked without a waiting result");

endmodule
